### rtl/core/gbn_pkg.sv
package gbn_pkg;

   // widest sequence number the command path carries
   localparam int SeqMaxBits = 32;

   // window fields
   localparam int WinBits = 7;

   // item kinds
   localparam logic [1:0] KindOffer   = 2'd0;
   localparam logic [1:0] KindAck     = 2'd1;
   localparam logic [1:0] KindTimeout = 2'd2;

   // timer commands
   localparam logic [1:0] TimerNone  = 2'd0;
   localparam logic [1:0] TimerStart = 2'd1;
   localparam logic [1:0] TimerStop  = 2'd2;

   // register indexes
   localparam logic CsrMaxWindow  = 1'b0;
   localparam logic CsrInitWindow = 1'b1;

   // reset values of the registers
   localparam logic [WinBits-1:0] MaxWindowReset  = 7'd64;
   localparam logic [WinBits-1:0] InitWindowReset = 7'd50;

   localparam logic [7:0] DupLimit     = 8'd3;
   localparam logic [1:0] TimeoutLimit = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] ack_no;
      logic        ack_ok;
   } req_type;

   typedef struct packed {
      logic               send_valid;
      logic [15:0]        send_seq;
      logic               accepted;
      logic [1:0]         timer_cmd;
      logic [WinBits-1:0] window_now;
      logic               halted;
      logic               last;
   } rsp_type;

   // one burst for the back end: count sends from from_seq, then the closing fields
   typedef struct packed {
      logic [SeqMaxBits-1:0] from_seq;
      logic [WinBits-1:0]    count;
      logic                  accepted;
      logic [1:0]            timer_cmd;
      logic [WinBits-1:0]    window_now;
      logic                  halted;
   } cmd_type;

   // force a window value into 1..limit
   function automatic logic [WinBits-1:0] win_clamp(input logic [WinBits-1:0] value,
                                                    input logic [WinBits-1:0] limit);
      logic [WinBits-1:0] w;
      w = value;
      if (w == '0) begin
         w = 7'd1;
      end
      if (w > limit) begin
         w = limit;
      end
      return w;
   endfunction

endpackage

### rtl/core/gbn_cmd_q.sv
module gbn_cmd_q
   import gbn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   // two slots, slot0 is the head
   cmd_type    slot0_ff, slot0_in;
   cmd_type    slot1_ff, slot1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign empty   = (cnt_ff == 2'd0);
   assign full    = (cnt_ff == 2'd2);
   assign head    = slot0_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (do_pop && do_push) begin
         if (cnt_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end else if (do_pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end else if (do_push) begin
         if (cnt_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/core/gbn_front.sv
module gbn_front
   import gbn_pkg::*;
#(
   parameter int SEQ_BITS   = 16,
   parameter int MAX_WINDOW = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [WinBits-1:0] csr_wdata,
   input  logic               take,
   input  req_type            req_data,
   output cmd_type            cmd
);

   localparam int SB = SEQ_BITS;
   localparam logic [WinBits-1:0] MaxWin = WinBits'(MAX_WINDOW);
   localparam logic [SB-1:0] SeqTop = '1;

   logic [WinBits-1:0] max_window_ff, max_window_in;
   logic [WinBits-1:0] init_window_ff, init_window_in;
   logic [SB-1:0]      base_ff, base_in;
   logic [SB-1:0]      next_ff, next_in;
   logic [SB-1:0]      resend_ff, resend_in;
   logic [WinBits-1:0] cwnd_ff, cwnd_in;
   logic [7:0]         dup_ff, dup_in;
   logic [SB-1:0]      lra_ff, lra_in;
   logic [1:0]         tmo_ff, tmo_in;
   logic               halt_ff, halt_in;

   logic [WinBits-1:0] eff_max;
   logic [WinBits-1:0] cw_half;
   logic [SB:0]        lim_wide;
   logic [SB-1:0]      loss_lim;
   logic [WinBits-1:0] loss_cnt;
   logic [WinBits-1:0] cw_inc;
   logic [SB+2:0]      room;
   logic [SB+2:0]      avail;
   logic [SB+2:0]      ack_cnt_w;
   logic [WinBits-1:0] ack_cnt;
   logic [SB-1:0]      ack;
   logic [7:0]         dup_inc;
   logic [1:0]         tmo_inc;
   logic [SB:0]        win_end;

   assign eff_max = win_clamp(max_window_ff, MaxWin);
   assign ack     = SB'(req_data.ack_no);

   // loss event: halve, resend from base up to min(base + window, next)
   always_comb begin
      cw_half = cwnd_ff >> 1;
      if (cw_half == '0) begin
         cw_half = 7'd1;
      end
      lim_wide = {1'b0, base_ff} + (SB+1)'(cw_half);
      loss_lim = (lim_wide > {1'b0, next_ff}) ? next_ff : lim_wide[SB-1:0];
      loss_cnt = (loss_lim > base_ff) ? WinBits'(loss_lim - base_ff) : '0;
      if (loss_cnt > MaxWin) begin
         loss_cnt = MaxWin;
      end
   end

   // new ack: grow window and resend what fits
   always_comb begin
      cw_inc = ({1'b0, cwnd_ff} + 8'd1 < {1'b0, eff_max}) ? cwnd_ff + 7'd1 : eff_max;
      room   = (SB+3)'(base_ff) + (SB+3)'(cw_inc) + (SB+3)'(1) - (SB+3)'(resend_ff);
      avail  = (SB+3)'(next_ff - resend_ff);
      ack_cnt_w = room[SB+2] ? '0 : room;
      if (ack_cnt_w > avail) begin
         ack_cnt_w = avail;
      end
      if (ack_cnt_w > (SB+3)'(MaxWin)) begin
         ack_cnt_w = (SB+3)'(MaxWin);
      end
      ack_cnt = WinBits'(ack_cnt_w);
   end

   assign dup_inc = (ack != lra_ff && dup_ff != 8'd255) ? dup_ff + 8'd1 : dup_ff;
   assign tmo_inc = (cwnd_ff == 7'd1 && tmo_ff < TimeoutLimit) ? tmo_ff + 2'd1 : tmo_ff;
   assign win_end = {1'b0, base_ff} + (SB+1)'(cwnd_ff);

   always_comb begin
      max_window_in  = max_window_ff;
      init_window_in = init_window_ff;
      base_in   = base_ff;
      next_in   = next_ff;
      resend_in = resend_ff;
      cwnd_in   = cwnd_ff;
      dup_in    = dup_ff;
      lra_in    = lra_ff;
      tmo_in    = tmo_ff;
      halt_in   = halt_ff;
      cmd       = '0;

      if (take && !halt_ff) begin
         case (req_data.kind)
            KindOffer: begin
               if (resend_ff == next_ff && {1'b0, next_ff} < win_end && next_ff != SeqTop) begin
                  cmd.accepted  = 1'b1;
                  cmd.from_seq  = SeqMaxBits'(next_ff);
                  cmd.count     = 7'd1;
                  cmd.timer_cmd = (next_ff == base_ff) ? TimerStart : TimerNone;
                  next_in   = next_ff + 1'b1;
                  resend_in = resend_ff + 1'b1;
               end
            end
            KindAck: begin
               if (req_data.ack_ok) begin
                  if (ack < base_ff) begin
                     dup_in = dup_inc;
                     if (dup_inc >= DupLimit) begin
                        lra_in       = ack;
                        cwnd_in      = cw_half;
                        dup_in       = '0;
                        resend_in    = loss_lim;
                        cmd.from_seq = SeqMaxBits'(base_ff);
                        cmd.count    = loss_cnt;
                     end
                  end else begin
                     cwnd_in = cw_inc;
                     if (resend_ff != '0 && resend_ff < next_ff) begin
                        cmd.from_seq = SeqMaxBits'(resend_ff);
                        cmd.count    = ack_cnt;
                        resend_in    = resend_ff + SB'(ack_cnt);
                     end
                     base_in = ack + 1'b1;
                  end
                  cmd.timer_cmd = (base_in == next_ff) ? TimerStop : TimerStart;
               end
            end
            KindTimeout: begin
               tmo_in = tmo_inc;
               if (tmo_inc >= TimeoutLimit) begin
                  halt_in       = 1'b1;
                  cmd.timer_cmd = TimerStop;
               end else begin
                  cwnd_in       = cw_half;
                  dup_in        = '0;
                  resend_in     = loss_lim;
                  cmd.from_seq  = SeqMaxBits'(base_ff);
                  cmd.count     = loss_cnt;
                  cmd.timer_cmd = TimerStart;
               end
            end
            default: begin
            end
         endcase
      end

      if (csr_we) begin
         case (csr_index)
            CsrMaxWindow: begin
               max_window_in = csr_wdata;
            end
            CsrInitWindow: begin
               init_window_in = csr_wdata;
               cwnd_in        = win_clamp(csr_wdata, eff_max);
            end
            default: begin
            end
         endcase
      end

      cmd.window_now = cwnd_in;
      cmd.halted     = halt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_window_ff  <= MaxWindowReset;
         init_window_ff <= InitWindowReset;
         base_ff   <= '0;
         next_ff   <= '0;
         resend_ff <= '0;
         cwnd_ff   <= win_clamp(InitWindowReset, win_clamp(MaxWindowReset, MaxWin));
         dup_ff    <= '0;
         lra_ff    <= '0;
         tmo_ff    <= '0;
         halt_ff   <= 1'b0;
      end else begin
         max_window_ff  <= max_window_in;
         init_window_ff <= init_window_in;
         base_ff   <= base_in;
         next_ff   <= next_in;
         resend_ff <= resend_in;
         cwnd_ff   <= cwnd_in;
         dup_ff    <= dup_in;
         lra_ff    <= lra_in;
         tmo_ff    <= tmo_in;
         halt_ff   <= halt_in;
      end
   end

endmodule

### rtl/core/gbn_back.sv
module gbn_back
   import gbn_pkg::*;
#(
   parameter int SEQ_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type q_head,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic               act_ff, act_in;
   cmd_type            cur_ff, cur_in;
   logic [WinBits-1:0] idx_ff, idx_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               advance;
   logic               is_last;
   logic [SEQ_BITS-1:0] seq;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign advance   = !out_valid_ff || rsp_pop;
   assign q_pop     = !act_ff && !q_empty;

   assign is_last = (cur_ff.count == '0) || (idx_ff == cur_ff.count - 7'd1);
   assign seq     = SEQ_BITS'(cur_ff.from_seq) + SEQ_BITS'(idx_ff);

   always_comb begin
      act_in       = act_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      if (act_ff && advance) begin
         out_valid_in      = 1'b1;
         out_in            = '0;
         out_in.send_valid = (cur_ff.count != '0);
         out_in.send_seq   = (cur_ff.count != '0) ? 16'(seq) : '0;
         out_in.window_now = cur_ff.window_now;
         out_in.halted     = cur_ff.halted;
         if (is_last) begin
            out_in.accepted  = cur_ff.accepted;
            out_in.timer_cmd = cur_ff.timer_cmd;
            out_in.last      = 1'b1;
            act_in           = 1'b0;
         end else begin
            idx_in = idx_ff + 7'd1;
         end
      end

      if (q_pop) begin
         act_in = 1'b1;
         cur_in = q_head;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
      if (reset) begin
         act_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### rtl/core/go_back_n_sender_window_top.sv
// go-back-n sender control with a halving congestion window. each req transfer is an
// offer, an ack or a timer expiry; the front end decides it and updates the window in the
// cycle it is taken, so req_full only rises when the two-entry command queue is full.
// the back end then walks the burst, one rsp transfer per cycle while rsp_pop is held high:
// an item gives max(1, sends) results, one for an offer, up to MAX_WINDOW (64) for a
// full-window resend, and the walker takes the next command only after the last result
// of the current one, so the walker is what bounds throughput. the last result of each item
// carries last, accepted and timer_cmd. csr writes take effect at once and are meant for
// idle periods; writing initial_window also reloads the congestion window. three timeouts
// at window one stop the block for good: from then on each item gives a single result
// with halted set
module go_back_n_sender_window_top
   import gbn_pkg::*;
#(
   parameter int SEQ_BITS   = 16,
   parameter int MAX_WINDOW = 64
) (
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_push,
   output logic               req_full,
   input  req_type            req_data,
   // results
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output rsp_type            rsp_data,
   // register writes
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [WinBits-1:0] csr_wdata
);

   logic    take;
   cmd_type cmd;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   cmd_type q_head;

   // an item is taken whenever the queue has room
   assign req_full = q_full;
   assign take     = req_push && !q_full;

   // front: classify and update window state
   gbn_front #(
      .SEQ_BITS   (SEQ_BITS),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .req_data  (req_data),
      .cmd       (cmd)
   );

   // burst commands waiting for the walker
   gbn_cmd_q u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (cmd),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // back: emit one result per cycle into the output register while the receiver keeps popping
   gbn_back #(
      .SEQ_BITS (SEQ_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a result that sends nothing is always the only one of its item
   a_nosend_is_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.send_valid |-> rsp_data.last)
      else $error("result without send is not last");

   // an accepted offer always sends its packet on its closing result
   a_accept_sends: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.accepted |-> rsp_data.send_valid && rsp_data.last)
      else $error("accepted offer without send");

   // the window stays within its bounds
   a_window_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.window_now != 7'd0 &&
                     rsp_data.window_now <= WinBits'(MAX_WINDOW))
      else $error("window out of range");

   // a halted block never starts the timer and never sends
   a_halt_no_start: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.halted |-> rsp_data.timer_cmd != TimerStart &&
                                        !rsp_data.send_valid)
      else $error("halted block started timer or sent");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import gbn_pkg::*;

   // sequence space of the block as built (SEQ_BITS 16, MAX_WINDOW 64)
   localparam int unsigned SeqTop    = 16'hFFFF;
   localparam int unsigned WindowCap = 64;
   // the one kind code the block has no use for
   localparam logic [1:0]  KindUnused = 2'd3;

   // tracks the sender window and the sends each item must cause
   class window_tracker;
      logic [WinBits-1:0] max_reg;
      logic [WinBits-1:0] init_reg;
      int unsigned base;
      int unsigned next_seq;
      int unsigned resend_at;
      int unsigned cwnd;
      int unsigned dup_cnt;
      int unsigned last_dup_ack;
      int unsigned timeouts;
      bit          halt;
      int unsigned burst[$];
      rsp_type     expected_sends[$];
      int          errors;

      function int unsigned limit_window();
         int unsigned m;
         m = max_reg;
         if (m < 1) m = 1;
         if (m > WindowCap) m = WindowCap;
         return m;
      endfunction

      function int unsigned start_window();
         int unsigned w;
         int unsigned m;
         w = init_reg;
         m = limit_window();
         if (w < 1) w = 1;
         if (w > m) w = m;
         return w;
      endfunction

      function void reset_state();
         max_reg = MaxWindowReset;
         init_reg = InitWindowReset;
         base = 0;
         next_seq = 0;
         resend_at = 0;
         cwnd = start_window();
         dup_cnt = 0;
         last_dup_ack = 0;
         timeouts = 0;
         halt = 1'b0;
         errors = 0;
         expected_sends.delete();
      endfunction

      function void write_reg(logic idx, logic [WinBits-1:0] value);
         if (idx == CsrMaxWindow) begin
            max_reg = value;
         end else begin
            init_reg = value;
            cwnd = start_window();
         end
      endfunction

      // loss event: halve the window and resend what fits in it from the base
      function void halve_and_resend();
         int unsigned lim;
         cwnd = cwnd >> 1;
         if (cwnd == 0) cwnd = 1;
         dup_cnt = 0;
         lim = base + cwnd;
         if (lim > next_seq) lim = next_seq;
         resend_at = lim;
         for (int unsigned s = base; s < lim && burst.size() < WindowCap; s++) begin
            burst.push_back(s & SeqTop);
         end
      endfunction

      function void take_item(req_type item);
         logic        took;
         logic [1:0]  timer;
         int unsigned m;
         int unsigned avail;
         int unsigned cnt;
         int          room;
         int          n;
         rsp_type     r;
         took = 1'b0;
         timer = TimerNone;
         burst.delete();
         if (!halt) begin
            if (item.kind == KindOffer) begin
               if (resend_at == next_seq && next_seq < base + cwnd && next_seq != SeqTop) begin
                  took = 1'b1;
                  burst.push_back(next_seq);
                  if (next_seq == base) timer = TimerStart;
                  next_seq = (next_seq + 1) & SeqTop;
                  resend_at = (resend_at + 1) & SeqTop;
               end
            end else if (item.kind == KindAck && item.ack_ok) begin
               if (item.ack_no < base) begin
                  if (item.ack_no != last_dup_ack && dup_cnt < 255) dup_cnt++;
                  if (dup_cnt >= DupLimit) begin
                     last_dup_ack = item.ack_no;
                     halve_and_resend();
                  end
               end else begin
                  m = limit_window();
                  cwnd = (cwnd + 1 < m) ? cwnd + 1 : m;
                  if (resend_at != 0 && resend_at < next_seq) begin
                     room = int'(cwnd) - (int'(resend_at) - int'(base) - 1);
                     if (room < 0) room = 0;
                     avail = next_seq - resend_at;
                     cnt = room;
                     if (cnt > avail) cnt = avail;
                     if (cnt > WindowCap) cnt = WindowCap;
                     for (int unsigned k = 0; k < cnt; k++) begin
                        burst.push_back((resend_at + k) & SeqTop);
                     end
                     resend_at += cnt;
                  end
                  base = (item.ack_no + 1) & SeqTop;
               end
               timer = (base == next_seq) ? TimerStop : TimerStart;
            end else if (item.kind == KindTimeout) begin
               if (cwnd == 1 && timeouts < TimeoutLimit) timeouts++;
               if (timeouts >= TimeoutLimit) begin
                  halt = 1'b1;
                  timer = TimerStop;
               end else begin
                  halve_and_resend();
                  timer = TimerStart;
               end
            end
         end
         n = (burst.size() == 0) ? 1 : burst.size();
         for (int k = 0; k < n; k++) begin
            r = '0;
            if (burst.size() != 0) begin
               r.send_valid = 1'b1;
               r.send_seq = 16'(burst[k]);
            end
            r.window_now = WinBits'(cwnd);
            r.halted = halt;
            if (k == n - 1) begin
               r.accepted = took;
               r.timer_cmd = timer;
               r.last = 1'b1;
            end
            expected_sends.push_back(r);
         end
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_send(rsp_type got);
         rsp_type want;
         if (expected_sends.size() == 0) begin
            $error("result with nothing outstanding: send_seq %0d last %0d",
                   got.send_seq, got.last);
            errors++;
            return;
         end
         want = expected_sends.pop_front();
         compare("send_valid", want.send_valid, got.send_valid);
         compare("send_seq", want.send_seq, got.send_seq);
         compare("accepted", want.accepted, got.accepted);
         compare("timer_cmd", want.timer_cmd, got.timer_cmd);
         compare("window_now", want.window_now, got.window_now);
         compare("halted", want.halted, got.halted);
         compare("last", want.last, got.last);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   req_type            req_data = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   rsp_type            rsp_data;
   logic               csr_we = 1'b0;
   logic               csr_index = CsrMaxWindow;
   logic [WinBits-1:0] csr_wdata = '0;

   window_tracker model = new;

   // pacing state shared by the driving processes
   int burst_left = 0;     // transfers left in the current sender burst
   int hold_asks = 0;      // bumped by the stimulus to ask for a long receiver hold-off
   int holds_done = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   go_back_n_sender_window_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // run guard, far beyond the slowest legal run
   initial begin
      #(10_000_000);
      $display("simulation failed");
      $finish;
   end

   // receiver: check every result transfer, then choose pop for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_pop && rsp_empty === 1'b0) model.check_send(rsp_data);
      if (hold_asks != holds_done) begin
         holds_done = hold_asks;
         hold_left = 400;
      end
      if (hold_left != 0) begin
         // long hold-off: the block must fill up and raise req_full
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(8, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_pop <= 1'b1;                        // no stalls at all
            1: rsp_pop <= 1'($urandom_range(0, 1));
            2: rsp_pop <= ($urandom_range(0, 3) == 0);   // heavy stalling
            default: rsp_pop <= ~rsp_pop;
         endcase
      end
   end

   function automatic req_type item_of(logic [1:0] kind, logic [15:0] ack, logic ok);
      req_type item;
      item.kind = kind;
      item.ack_no = ack;
      item.ack_ok = ok;
      return item;
   endfunction

   // one transfer on the input side; the sender works in bursts with gaps between
   task automatic push_item(input req_type item);
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full !== 1'b0);
      model.take_item(item);
      if (burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   // stop offering and let every expected result drain, plus the walker's tail
   task automatic settle();
      req_push <= 1'b0;
      while (model.expected_sends.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_windows(input logic [WinBits-1:0] max_w, input logic [WinBits-1:0] init_w,
                              input bit load_init);
      csr_we <= 1'b1;
      csr_index <= CsrMaxWindow;
      csr_wdata <= max_w;
      @(posedge clock);
      model.write_reg(CsrMaxWindow, max_w);
      if (load_init) begin
         csr_index <= CsrInitWindow;
         csr_wdata <= init_w;
         @(posedge clock);
         model.write_reg(CsrInitWindow, init_w);
      end
      csr_we <= 1'b0;
   endtask

   // random item shaped by the current window: mostly offers and acks that
   // slide the window, with duplicates, timeouts and some noise mixed in
   function automatic req_type pick_item();
      req_type     item;
      int unsigned roll;
      int unsigned span;
      roll = $urandom_range(0, 99);
      item = item_of(KindOffer, 16'($urandom), 1'b1);
      if (roll < 8) begin
         case ($urandom_range(0, 2))
            0: begin
               item.kind = KindUnused;
               item.ack_ok = 1'($urandom_range(0, 1));
            end
            1: begin
               item.kind = KindAck;
               item.ack_ok = 1'b0;
            end
            default: item.kind = KindAck;   // well-formed ack anywhere in the space
         endcase
      end else if (roll < 16) begin
         // keep the halting timeout for the final phase
         if (!(model.cwnd == 1 && model.timeouts + 1 >= TimeoutLimit)) item.kind = KindTimeout;
      end else if (roll < 50) begin
         item.kind = KindOffer;
      end else if (roll < 80) begin
         item.kind = KindAck;
         if (model.next_seq > model.base) begin
            item.ack_no = 16'(model.base + $urandom_range(0, model.next_seq - model.base - 1));
         end else begin
            item.ack_no = 16'(model.base);
         end
      end else if (roll < 93) begin
         if (model.base != 0) begin
            span = (model.base - 1 < 4) ? model.base - 1 : 4;
            item.kind = KindAck;
            item.ack_no = 16'(model.base - 1 - $urandom_range(0, span));
         end
      end else begin
         item.kind = KindAck;
         item.ack_no = 16'(model.next_seq + $urandom_range(0, 3));
      end
      return item;
   endfunction

   initial begin
      logic [WinBits-1:0] max_tab [6];
      logic [WinBits-1:0] init_tab [6];
      bit                 load_tab [6];
      max_tab = '{7'd64, 7'd1, 7'd127, 7'd20, 7'd6, 7'd64};
      init_tab = '{7'd50, 7'd1, 7'd64, 7'd0, 7'd20, 7'd33};
      load_tab = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

      model.reset_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset window, empty-window timeout, ignored items, duplicates
      push_item(item_of(KindTimeout, 16'h0000, 1'b1));
      repeat (4) push_item(item_of(KindOffer, 16'h0000, 1'b0));
      push_item(item_of(KindAck, 16'hFFFF, 1'b0));      // malformed ack, ignored
      push_item(item_of(KindUnused, 16'hFFFF, 1'b1));   // unused kind, ignored
      push_item(item_of(KindAck, 16'h0001, 1'b1));
      push_item(item_of(KindAck, 16'h0000, 1'b1));      // matches last_dup_ack: not counted
      repeat (3) push_item(item_of(KindAck, 16'h0001, 1'b1));   // third duplicate: loss
      push_item(item_of(KindTimeout, 16'h0000, 1'b1));
      push_item(item_of(KindOffer, 16'h0000, 1'b0));
      push_item(item_of(KindAck, 16'h0002, 1'b1));
      push_item(item_of(KindAck, 16'd40, 1'b1));        // ack past next_seq
      push_item(item_of(KindOffer, 16'h0000, 1'b0));
      push_item(item_of(KindAck, 16'hFFFF, 1'b1));      // base wraps to zero
      push_item(item_of(KindAck, 16'h0000, 1'b0));
      push_item(item_of(KindTimeout, 16'h0000, 1'b1));
      push_item(item_of(KindOffer, 16'h0000, 1'b0));

      // random phases, each under its own window settings
      for (int p = 0; p < 6; p++) begin
         if (p != 0) begin
            settle();
            set_windows(max_tab[p], init_tab[p], load_tab[p]);
         end
         for (int i = 0; i < 75; i++) begin
            if (p == 0 && i == 30) hold_asks++;
            push_item(pick_item());
         end
      end

      // widest window, then a short mix around the current base
      settle();
      set_windows(7'd64, 7'd64, 1'b1);
      push_item(item_of(KindOffer, 16'h0000, 1'b0));
      push_item(item_of(KindAck, 16'hFFFF, 1'b1));
      push_item(item_of(KindOffer, 16'h0000, 1'b0));
      push_item(item_of(KindTimeout, 16'h0000, 1'b1));

      // window one, then timeouts until the block halts for good
      settle();
      set_windows(7'd64, 7'd1, 1'b1);
      while (!model.halt) push_item(item_of(KindTimeout, 16'h0000, 1'b1));
      push_item(item_of(KindOffer, 16'h0000, 1'b0));
      push_item(item_of(KindAck, 16'h0000, 1'b1));
      push_item(item_of(KindTimeout, 16'h0000, 1'b1));
      push_item(item_of(KindUnused, 16'h1234, 1'b1));

      settle();
      if (model.errors == 0 && model.expected_sends.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/gbn_pkg.sv
rtl/core/gbn_cmd_q.sv
rtl/core/gbn_front.sv
rtl/core/gbn_back.sv
rtl/core/go_back_n_sender_window_top.sv
sim/tb.sv
